// ----- src/catmull_rom_rate_converter_macros.svh -----
// Assertion macros shared by the converter's modules.
// Each macro checks a property at the rising clock edge and is
// disabled while the active-low reset is asserted.
`ifndef CATMULL_ROM_RATE_CONVERTER_MACROS_SVH
`define CATMULL_ROM_RATE_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define CRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- src/crr_pkg.sv -----
package crr_pkg;

    // Number formats.
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_BITS   = 21;
    localparam int POS_BITS    = 24;
    localparam int COEF_BITS   = SAMPLE_BITS + 4;
    localparam int H_BITS      = SAMPLE_BITS + 6;
    localparam int PROD_BITS   = H_BITS + FRAC_BITS + 1;

    // Window and queue sizes. Queue depths are powers of two.
    localparam int WIN_DEPTH    = 4;
    localparam int EXT_TAPS     = 2 * WIN_DEPTH;
    localparam int CMD_DEPTH    = 2;
    localparam int RES_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int HORNER_STEPS = 3;

    localparam logic [1:0] SEEN_MAX = 2'(WIN_DEPTH - 1);

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);
    localparam logic [STEP_BITS-1:0] MIN_STEP   = STEP_BITS'(1) << (FRAC_BITS - 3);
    localparam logic [POS_BITS-1:0]  ONE_POS    = POS_BITS'(1) << FRAC_BITS;

    localparam logic signed [H_BITS-1:0] SAT_HI = H_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [H_BITS-1:0] SAT_LO = -SAT_HI - H_BITS'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // One classified input word as handed from the front to the back.
    typedef struct packed {
        t_sample [WIN_DEPTH-1:0] win;       // win[WIN_DEPTH-1] is the newest sample
        logic    [1:0]           base;      // window tap of integer position zero, minus one
        logic    [1:0]           limit_int; // integer part of the position limit
        logic                    fin;       // final word of the stream
        logic                    adv;       // window base moves on by one sample
    } t_cmd;

    typedef struct packed {
        t_sample sample_out;
        logic    last;
        logic    stream_done;
    } t_res;

endpackage

// ----- src/crr_front.sv -----
module crr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crr_pkg::t_sample i_sample,
    input  logic            i_end_of_stream,
    input  logic            i_cmd_full,
    output logic            o_cmd_push,
    output crr_pkg::t_cmd   o_cmd
);
    import crr_pkg::*;

    t_sample    r_win [WIN_DEPTH];
    t_sample    n_win [WIN_DEPTH];
    logic [1:0] r_seen;
    logic       seen_two;

    assign o_cmd_push = i_push && !i_cmd_full;
    assign seen_two   = (r_seen >= 2'd2);

    // The first sample of a stream fills the whole window, so taps older than
    // the stream already hold the first sample and the low-end clamp is free.
    always_comb begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            n_win[i] = (r_seen == '0) ? i_sample : r_win[i+1];
        end
        n_win[WIN_DEPTH-1] = i_sample;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            o_cmd.win[i] = n_win[i];
        end
        o_cmd.base = seen_two ? 2'd0 : 2'd2 - r_seen;
        if (i_end_of_stream) begin
            o_cmd.limit_int = seen_two ? 2'd3 : 2'd1 + r_seen;
        end else begin
            o_cmd.limit_int = seen_two ? 2'd1 : 2'd0;
        end
        o_cmd.fin = i_end_of_stream;
        o_cmd.adv = !i_end_of_stream && seen_two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else if (o_cmd_push) begin
            if (i_end_of_stream) begin
                r_seen <= '0;
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                r_seen <= (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 2'd1;
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= n_win[i];
                end
            end
        end
    end

endmodule

// ----- src/crr_cmd_fifo.sv -----
module crr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output crr_pkg::t_cmd o_data
);
    import crr_pkg::*;

    t_cmd                    r_mem [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] r_wr;
    logic [CMD_PTR_BITS-1:0] r_rd;
    logic [CMD_PTR_BITS:0]   r_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_full  = (r_count == (CMD_PTR_BITS + 1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/crr_res_fifo.sv -----
`include "catmull_rom_rate_converter_macros.svh"

module crr_res_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crr_pkg::t_res i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output crr_pkg::t_res o_data
);
    import crr_pkg::*;

    t_res                    r_mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] r_wr;
    logic [RES_PTR_BITS-1:0] r_rd;
    logic [RES_PTR_BITS:0]   r_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_full  = (r_count == (RES_PTR_BITS + 1)'(RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `CRR_ASSERT_NEVER(a_res_count_bound, i_clk, i_rst_n, r_count > (RES_PTR_BITS + 1)'(RES_DEPTH), "result queue count above depth")

endmodule

// ----- src/crr_back.sv -----
`include "catmull_rom_rate_converter_macros.svh"

module crr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step_ratio_we,
    input  logic [crr_pkg::STEP_BITS-1:0]   i_step_ratio,
    input  logic                            i_cmd_empty,
    input  crr_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output crr_pkg::t_res                   o_res
);
    import crr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_MUL   = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    localparam logic [POS_BITS-1:0] POS_BOUND =
        POS_BITS'((WIN_DEPTH - 1) << FRAC_BITS) + POS_BITS'(1 << STEP_BITS);

    t_state                       r_state;
    logic [STEP_BITS-1:0]         r_step;
    logic [POS_BITS-1:0]          r_pos;
    logic [1:0]                   r_k;
    t_cmd                         r_cmd;
    logic signed [H_BITS-1:0]     r_h;
    logic signed [COEF_BITS-1:0]  r_b2;
    logic signed [COEF_BITS-1:0]  r_c2;
    logic signed [COEF_BITS-1:0]  r_d2;
    logic [FRAC_BITS-1:0]         r_frac;
    logic                         r_last;

    logic [STEP_BITS-1:0]             step_eff;
    logic [POS_BITS-1:0]              limit;
    logic [POS_BITS-1:0]              pos_next;
    logic                             in_range;
    logic [2:0]                       shift;
    logic [EXT_TAPS*SAMPLE_BITS-1:0]  ext;
    logic [EXT_TAPS*SAMPLE_BITS-1:0]  ext_sh;
    logic signed [COEF_BITS-1:0]      pe [WIN_DEPTH];
    logic signed [COEF_BITS-1:0]      a2;
    logic signed [COEF_BITS-1:0]      b2;
    logic signed [COEF_BITS-1:0]      c2;
    logic signed [COEF_BITS-1:0]      d2;
    logic signed [COEF_BITS-1:0]      coef_sel;
    logic signed [FRAC_BITS:0]        frac_s;
    logic signed [PROD_BITS-1:0]      prod;
    logic signed [H_BITS-1:0]         h_new;
    logic signed [H_BITS-1:0]         h_adj;
    logic signed [H_BITS-1:0]         h_half;
    logic signed [H_BITS-1:0]         h_sat;

    assign step_eff = (r_step < MIN_STEP) ? MIN_STEP : r_step;
    assign limit    = POS_BITS'(r_cmd.limit_int) << FRAC_BITS;
    assign in_range = (r_pos < limit);
    assign pos_next = r_pos + POS_BITS'(step_eff);

    // Taps above the newest sample repeat it, which is the high-end clamp.
    assign ext    = {{WIN_DEPTH{r_cmd.win[WIN_DEPTH-1]}}, r_cmd.win};
    assign shift  = 3'(r_cmd.base) + 3'(r_pos[FRAC_BITS+1:FRAC_BITS]);
    assign ext_sh = ext >> (SAMPLE_BITS * shift);

    always_comb begin
        for (int j = 0; j < WIN_DEPTH; j++) begin
            pe[j] = COEF_BITS'($signed(ext_sh[j*SAMPLE_BITS +: SAMPLE_BITS]));
        end
        // Doubled Catmull-Rom coefficients.
        a2 = pe[3] - pe[0] + ((pe[1] - pe[2]) <<< 1) + (pe[1] - pe[2]);
        b2 = (pe[0] <<< 1) - (pe[1] <<< 2) - pe[1] + (pe[2] <<< 2) - pe[3];
        c2 = pe[2] - pe[0];
        d2 = pe[1] <<< 1;
    end

    always_comb begin
        case (r_k)
            2'd0:    coef_sel = r_b2;
            2'd1:    coef_sel = r_c2;
            default: coef_sel = r_d2;
        endcase
    end

    // One Horner step: floor(h * frac / 2^FRAC_BITS) plus the next coefficient.
    assign frac_s = $signed({1'b0, r_frac});
    assign prod   = r_h * frac_s;
    assign h_new  = prod[H_BITS+FRAC_BITS-1:FRAC_BITS] + H_BITS'(coef_sel);

    // Halve toward zero, then saturate.
    assign h_adj  = r_h + $signed({{(H_BITS-1){1'b0}}, r_h[H_BITS-1]});
    assign h_half = h_adj >>> 1;
    assign h_sat  = (h_half > SAT_HI) ? SAT_HI : ((h_half < SAT_LO) ? SAT_LO : h_half);

    assign o_res.sample_out  = h_sat[SAMPLE_BITS-1:0];
    assign o_res.last        = r_last;
    assign o_res.stream_done = r_last && r_cmd.fin;
    assign o_res_push        = (r_state == S_OUT) && !i_res_full;
    assign o_cmd_pop         = (r_state == S_IDLE) && !i_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_RESET;
            r_pos   <= '0;
            r_k     <= '0;
        end else begin
            if (i_step_ratio_we) begin
                r_step <= i_step_ratio;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (in_range) begin
                        r_pos   <= pos_next;
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end else begin
                        if (r_cmd.fin) begin
                            r_pos <= '0;
                        end else if (r_cmd.adv) begin
                            r_pos <= r_pos - ONE_POS;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'(HORNER_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == S_CHECK) && in_range) begin
            r_h    <= H_BITS'(a2);
            r_b2   <= b2;
            r_c2   <= c2;
            r_d2   <= d2;
            r_frac <= r_pos[FRAC_BITS-1:0];
            r_last <= (pos_next >= limit);
        end else if (r_state == S_MUL) begin
            r_h <= h_new;
        end
    end

    `CRR_ASSERT_NEVER(a_pos_bound, i_clk, i_rst_n, r_pos >= POS_BOUND, "output position out of range")
    `CRR_ASSERT(a_flush_clears_pos, i_clk, i_rst_n, (r_state == S_CHECK && !in_range && r_cmd.fin) |=> (r_pos == '0), "flush did not clear position")
    `CRR_ASSERT(a_last_ends_word, i_clk, i_rst_n, (o_res_push && o_res.last) |=> (r_state == S_CHECK && !in_range), "last result but positions remain")
    `CRR_ASSERT(a_more_after_not_last, i_clk, i_rst_n, (o_res_push && !o_res.last) |=> (r_state == S_CHECK && in_range), "result not marked last but word ended")

endmodule

// ----- src/catmull_rom_rate_converter.sv -----
// Each result passes through the check, Horner multiply and output states of the back end; a word
// with no result passes only through the idle and check states. The shared Horner multiplier
// serves one result at a time, and the back end takes no new word before it is through with
// the last (up to 8 results per word, 24 on the final one).
// Reset is synchronous and active low: it clears the window, the position, both queues
// and loads a step ratio of 1.0.
module catmull_rom_rate_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step_ratio_we,
    input  logic [crr_pkg::STEP_BITS-1:0]     i_step_ratio,
    input  logic                              push,
    output logic                              full,
    input  logic signed [crr_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                              i_end_of_stream,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [crr_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                              o_last,
    output logic                              o_stream_done
);
    import crr_pkg::*;

    // The front end keeps the four-sample window and the count of samples seen.
    // For every accepted word it builds a command holding the shifted window,
    // the tap that the integer position zero maps to and the position limit
    // for this word, then writes it into a short command queue.
    //
    // The back end owns the output position. It takes one command at a time and
    // walks the positions below the limit. Each position goes through tap
    // selection and coefficient setup, Horner evaluation on a single multiplier,
    // and then a last step that halves, saturates and writes the
    // result word into the result queue. Either side can stall on its own: the
    // front keeps accepting words while the back is busy, until the command
    // queue is full, and the back keeps working until the result queue is full.

    t_cmd cmd_in;
    t_cmd cmd_out;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_res res_in;
    t_res res_out;
    logic res_push;
    logic res_full;

    crr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_sample        (i_sample),
        .i_end_of_stream (i_end_of_stream),
        .i_cmd_full      (cmd_full),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    crr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    crr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_ratio_we (i_step_ratio_we),
        .i_step_ratio    (i_step_ratio),
        .i_cmd_empty     (cmd_empty),
        .i_cmd           (cmd_out),
        .o_cmd_pop       (cmd_pop),
        .i_res_full      (res_full),
        .o_res_push      (res_push),
        .o_res           (res_in)
    );

    crr_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    // The input side is full exactly when the command queue is.
    assign full          = cmd_full;
    assign o_sample_out  = res_out.sample_out;
    assign o_last        = res_out.last;
    assign o_stream_done = res_out.stream_done;

endmodule
